>>> rtl/sorted_unique_set_table_macros.svh
// ----------------------------------------------------------------------------
// sorted unique set table assertion macros
// clocked implication checks used by sust_ctrl
// ----------------------------------------------------------------------------
`ifndef SORTED_UNIQUE_SET_TABLE_MACROS_SVH
`define SORTED_UNIQUE_SET_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SUST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sust: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define SUST_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sust: next-cycle check failed");

`endif

>>> rtl/sust_pkg.sv
// ----------------------------------------------------------------------------
// sust_pkg
// shared types and constants of the sorted unique set table
// ----------------------------------------------------------------------------
`default_nettype none

package sust_pkg;

    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 6;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_DUMP   = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        SC_INSERTED  = 3'd0,
        SC_DUPLICATE = 3'd1,
        SC_FULL      = 3'd2,
        SC_DELETED   = 3'd3,
        SC_NOTFOUND  = 3'd4,
        SC_ELEMENT   = 3'd5,
        SC_EMPTY     = 3'd6
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_op;    // single-result item: update table, load result
        logic start_dump; // dump of a non-empty table begins
        logic dump_step;  // emit head entry and rotate
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;      // table holds no values
        logic dump_last;  // current dump step emits the final entry
    } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/sust_in_if.sv
// ----------------------------------------------------------------------------
// sust_in_if
// request channel: one op and value per item
// ----------------------------------------------------------------------------
`default_nettype none

interface sust_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/sust_out_if.sv
// ----------------------------------------------------------------------------
// sust_out_if
// result channel: status, item, count and last per item
// ----------------------------------------------------------------------------
`default_nettype none

interface sust_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] item;
    logic [5:0]         count;
    logic               last;

    modport source (output valid, output status, output item, output count,
                    output last, input ready);
    modport sink   (input valid, input status, input item, input count,
                    input last, output ready);
endinterface

`default_nettype wire

>>> rtl/sust_ctrl.sv
// ----------------------------------------------------------------------------
// sust_ctrl
// controller: request handshake, dump sequencing, result valid
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_unique_set_table_macros.svh"

module sust_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire sust_pkg::op_t     req_op,
    output logic                   req_ready,
    input  wire logic              rsp_ready,
    output logic                   rsp_valid,
    input  wire sust_pkg::dp_status_t dp_status,
    output sust_pkg::ctrl_cmd_t    cmd
);
    import sust_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   accept;

    assign out_free = !out_valid_reg || rsp_ready;
    assign accept   = req_valid && req_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && req_op == OP_DUMP && !dp_status.empty)
                    state_next = S_DUMP;
            end
            S_DUMP:
            begin
                if (out_free && dp_status.dump_last)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready      = 1'b0;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = out_free;
                if (accept)
                begin
                    case (req_op)
                        OP_INSERT, OP_DELETE: cmd.load_op = 1'b1;
                        OP_DUMP:
                        begin
                            cmd.load_op    = dp_status.empty;
                            cmd.start_dump = !dp_status.empty;
                        end
                        default: ;
                    endcase
                end
            end
            S_DUMP:  cmd.dump_step = out_free;
            default: ;
        endcase
        out_valid_next = out_valid_reg && !rsp_ready;
        if (cmd.load_op || cmd.dump_step)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

    `SUST_ASSERT_IMP(a_cmd_excl, cmd.load_op || cmd.start_dump, !cmd.dump_step)
    `SUST_ASSERT_NXT(a_dump_enters, cmd.start_dump, state_reg == S_DUMP)
    `SUST_ASSERT_NXT(a_dump_leaves, cmd.dump_step && dp_status.dump_last,
                     state_reg == S_IDLE && rsp_valid)
    `SUST_ASSERT_NXT(a_result_held, rsp_valid && !rsp_ready, rsp_valid)

endmodule

`default_nettype wire

>>> rtl/sust_dpath.sv
// ----------------------------------------------------------------------------
// sust_dpath
// datapath: compare-and-shift cell row, fill count, result register
// ----------------------------------------------------------------------------
`default_nettype none

module sust_dpath #(
    parameter int CAPACITY = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire sust_pkg::op_t          req_op,
    input  wire logic signed [31:0]     req_value,
    input  wire sust_pkg::ctrl_cmd_t    cmd,
    output sust_pkg::dp_status_t        dp_status,
    output logic [2:0]                  rsp_status,
    output logic signed [31:0]          rsp_item,
    output logic [5:0]                  rsp_count,
    output logic                        rsp_last
);
    import sust_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic signed [VALUE_W-1:0] cell_reg  [CAPACITY];
    logic signed [VALUE_W-1:0] cell_next [CAPACITY];
    logic signed [VALUE_W-1:0] from_left [CAPACITY];
    logic signed [VALUE_W-1:0] from_right[CAPACITY];
    logic [CAPACITY-1:0]       lt;
    logic [CAPACITY-1:0]       lt_left;
    logic [CAPACITY-1:0]       eq;
    logic [CW-1:0]             fill_reg, fill_next, fill_m1;
    logic [IW-1:0]             idx_reg, idx_next;
    logic                      hit, full, last_step;

    status_t                   status_reg, status_next;
    logic signed [VALUE_W-1:0] item_reg, item_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic                      last_reg, last_next;

    assign fill_m1   = fill_reg - 1'b1;
    assign full      = fill_reg == CW'(CAPACITY);
    assign hit       = |eq;
    assign last_step = CW'(idx_reg) == fill_m1;

    // per-cell compares against the request value
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            lt[i] = (CW'(i) < fill_reg) && (cell_reg[i] < req_value);
            eq[i] = (CW'(i) < fill_reg) && (cell_reg[i] == req_value);
        end
        from_left[0] = req_value;
        lt_left[0]   = 1'b0;
        for (int i = 1; i < CAPACITY; i++)
        begin
            from_left[i] = cell_reg[i-1];
            lt_left[i]   = lt[i-1];
        end
        for (int i = 0; i < CAPACITY - 1; i++)
            from_right[i] = cell_reg[i+1];
        from_right[CAPACITY-1] = cell_reg[CAPACITY-1];
    end

    always_comb
    begin
        cell_next   = cell_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        item_next   = item_reg;
        count_next  = count_reg;
        last_next   = last_reg;
        if (cmd.load_op)
        begin
            item_next = req_value;
            last_next = 1'b1;
            case (req_op)
                OP_INSERT:
                begin
                    if (hit)
                        status_next = SC_DUPLICATE;
                    else if (full)
                        status_next = SC_FULL;
                    else
                    begin
                        status_next = SC_INSERTED;
                        fill_next   = fill_reg + 1'b1;
                        for (int i = 0; i < CAPACITY; i++)
                            if (!lt[i])
                                cell_next[i] = lt_left[i] ? req_value : from_left[i];
                    end
                end
                OP_DELETE:
                begin
                    if (hit)
                    begin
                        status_next = SC_DELETED;
                        fill_next   = fill_m1;
                        for (int i = 0; i < CAPACITY; i++)
                            if (!lt[i])
                                cell_next[i] = from_right[i];
                    end
                    else
                        status_next = SC_NOTFOUND;
                end
                default:
                begin
                    // dump of an empty table
                    status_next = SC_EMPTY;
                    item_next   = '0;
                end
            endcase
            count_next = COUNT_W'(fill_next);
        end
        else if (cmd.start_dump)
            idx_next = '0;
        else if (cmd.dump_step)
        begin
            status_next = SC_ELEMENT;
            item_next   = cell_reg[0];
            count_next  = COUNT_W'(fill_reg);
            last_next   = last_step;
            idx_next    = idx_reg + 1'b1;
            // rotate the occupied cells left by one
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (CW'(i) < fill_m1)
                    cell_next[i] = from_right[i];
                else if (CW'(i) == fill_m1)
                    cell_next[i] = cell_reg[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
            cell_reg[i] <= cell_next[i];
        idx_reg    <= idx_next;
        status_reg <= status_next;
        item_reg   <= item_next;
        count_reg  <= count_next;
        last_reg   <= last_next;
    end

    assign dp_status.empty     = fill_reg == '0;
    assign dp_status.dump_last = last_step;
    assign rsp_status          = status_reg;
    assign rsp_item            = item_reg;
    assign rsp_count           = count_reg;
    assign rsp_last            = last_reg;

endmodule

`default_nettype wire

>>> rtl/sorted_unique_set_table.sv
// ----------------------------------------------------------------------------
// sorted_unique_set_table
// ordered set of distinct signed 32-bit values with insert, delete and dump
// ----------------------------------------------------------------------------
// usage
//   req carries op and value; rsp carries status, item, count and last
//   insert and delete: the whole cell row compares the value
//   at once and shifts right (insert) or left (delete) in the same edge
//   each such item gives one result, valid in the cycle after acceptance
//   a dump gives one result per stored value, one per cycle unless stalled,
//   ascending; the cell row rotates left by one each step, so after count
//   steps the order is restored; an empty table gives a single empty result
//   throughput: one item per cycle for insert and delete while rsp does not
//   stall; a dump of a non-empty table takes the accepting cycle, then one
//   step per value, an empty dump no step; the output register sets the pace
//   a new item is taken while the previous result waits, as long as the
//   receiver takes that result in the same cycle
//   when rsp stalls, the result holds and req stays not ready
//   unknown op codes are accepted and dropped with no result
//   reset clears the fill count and all handshake state; stored values are
//   never read until written, so the cell row has no reset
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_set_table #(
    parameter int CAPACITY = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sust_in_if.sink    req,
    sust_out_if.source rsp
);
    import sust_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;
    op_t        req_op;

    // raw op bits as a code; the unused code falls to the default arms
    assign req_op = op_t'(req.op);

    sust_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req_op),
        .req_ready (req.ready),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    sust_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_op     (req_op),
        .req_value  (req.value),
        .cmd        (cmd),
        .dp_status  (dp_status),
        .rsp_status (rsp.status),
        .rsp_item   (rsp.item),
        .rsp_count  (rsp.count),
        .rsp_last   (rsp.last)
    );

endmodule

`default_nettype wire
